[hw/rtl/agd_pkg.sv]
`default_nettype none

package agd_pkg;

    localparam int NIBBLE_COUNT = 30;
    localparam int QUEUE_DEPTH  = 2;
    localparam logic [4:0] POS_FIRST_HIST  = 5'd0;
    localparam logic [4:0] POS_SECOND_HIST = 5'd1;
    localparam logic [4:0] POS_LAST        = 5'd31;

    localparam logic [3:0] FILT_NONE = 4'd0;
    localparam logic [3:0] FILT_ONE  = 4'd1;
    localparam logic [3:0] FILT_TWO  = 4'd2;
    localparam logic [3:0] FILT_TRI  = 4'd3;

    typedef struct packed {
        logic [31:0] coded_header;
        logic [63:0] nibble_bytes_low;
        logic [55:0] nibble_bytes_high;
    } group_word_t;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic [4:0]         sample_position;
        logic               last_of_group;
    } sample_word_t;

    typedef struct packed {
        logic signed [7:0]               k1;
        logic signed [7:0]               k2;
        logic [3:0]                      shift;
        logic signed [15:0]              hist1;
        logic signed [15:0]              hist2;
        logic [4*NIBBLE_COUNT-1:0]       nibbles;
    } job_t;

    function automatic logic signed [7:0] coef_first(input logic [3:0] filt);
        logic signed [7:0] k;
        unique case (filt)
            FILT_ONE: k = 8'sd60;
            FILT_TWO: k = 8'sd115;
            FILT_TRI: k = 8'sd98;
            default:  k = 8'sd0;
        endcase
        return k;
    endfunction

    function automatic logic signed [7:0] coef_second(input logic [3:0] filt);
        logic signed [7:0] k;
        unique case (filt)
            FILT_TWO: k = -8'sd52;
            FILT_TRI: k = -8'sd55;
            default:  k = 8'sd0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/agd_front.sv]
`default_nettype none

module agd_front (
    input  wire logic                 group_valid,
    output      logic                 group_stall,
    input  wire agd_pkg::group_word_t group_word,
    output      logic                 push_valid,
    input  wire logic                 push_full,
    output      agd_pkg::job_t        push_job
);

    logic [119:0] bytes;
    logic [31:0]  hdr;

    assign hdr   = group_word.coded_header;
    assign bytes = {group_word.nibble_bytes_high, group_word.nibble_bytes_low};

    assign push_valid  = group_valid;
    assign group_stall = push_full;

    always_comb
    begin
        push_job.k1    = agd_pkg::coef_first(hdr[3:0]);
        push_job.k2    = agd_pkg::coef_second(hdr[3:0]);
        push_job.shift = hdr[19:16];
        push_job.hist2 = {hdr[15:4], 4'b0000};
        push_job.hist1 = {hdr[31:20], 4'b0000};
        // order nibbles so the next one to decode always sits at the bottom
        for (int b = 0; b < agd_pkg::NIBBLE_COUNT / 2; b++)
        begin
            push_job.nibbles[8*b +: 4]     = bytes[8*b+4 +: 4];
            push_job.nibbles[8*b+4 +: 4]   = bytes[8*b +: 4];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/agd_queue.sv]
`default_nettype none

module agd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output      logic           push_full,
    input  wire agd_pkg::job_t  push_job,
    output      logic           pop_valid,
    input  wire logic           pop,
    output      agd_pkg::job_t  pop_job
);

    agd_pkg::job_t entry_reg [agd_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_full = (count_reg == 2'(agd_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !push_full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/agd_back.sv]
`default_nettype none

module agd_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  job_valid,
    output      logic                  job_pop,
    input  wire agd_pkg::job_t         job,
    output      logic                  sample_valid,
    input  wire logic                  sample_stall,
    output      agd_pkg::sample_word_t sample_word
);

    logic                busy_reg, busy_next;
    logic [4:0]          pos_reg, pos_next;
    logic signed [7:0]   k1_reg, k1_next;
    logic signed [7:0]   k2_reg, k2_next;
    logic [3:0]          shift_reg, shift_next;
    logic signed [15:0]  h1_reg, h1_next;
    logic signed [15:0]  h2_reg, h2_next;
    logic [4*agd_pkg::NIBBLE_COUNT-1:0] nib_reg, nib_next;
    logic                out_valid_reg, out_valid_next;
    agd_pkg::sample_word_t out_word_reg, out_word_next;

    logic                advance, emit, load, decoding;
    logic signed [15:0]  scaled;
    logic signed [25:0]  acc;
    logic signed [19:0]  quot;
    logic signed [15:0]  dec_sample;
    logic signed [15:0]  emit_sample;

    assign advance  = !out_valid_reg || !sample_stall;
    assign emit     = busy_reg && advance;
    assign load     = job_valid && (!busy_reg || (emit && pos_reg == agd_pkg::POS_LAST));
    assign job_pop  = load;
    assign decoding = (pos_reg != agd_pkg::POS_FIRST_HIST)
                   && (pos_reg != agd_pkg::POS_SECOND_HIST);

    assign sample_valid = out_valid_reg;
    assign sample_word  = out_word_reg;

    always_comb
    begin
        scaled = $signed({nib_reg[3:0], 12'b0}) >>> shift_reg;
        acc    = 26'(scaled) * 26'sd64 + 26'(k1_reg * h1_reg) + 26'(k2_reg * h2_reg);
        // truncate toward zero
        quot   = 20'(acc >>> 6) + {19'd0, acc[25] && (acc[5:0] != 6'd0)};
        unique if (quot > 20'sd32767)
        begin
            dec_sample = 16'sh7FFF;
        end
        else if (quot < -20'sd32768)
        begin
            dec_sample = 16'sh8000;
        end
        else
        begin
            dec_sample = quot[15:0];
        end

        unique case (pos_reg)
            agd_pkg::POS_FIRST_HIST:  emit_sample = h2_reg;
            agd_pkg::POS_SECOND_HIST: emit_sample = h1_reg;
            default:                  emit_sample = dec_sample;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        shift_next     = shift_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        nib_next       = nib_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;

        if (advance)
        begin
            out_valid_next = emit;
        end

        if (emit)
        begin
            out_word_next.pcm_sample      = emit_sample;
            out_word_next.sample_position = pos_reg;
            out_word_next.last_of_group   = (pos_reg == agd_pkg::POS_LAST);
            pos_next = pos_reg + 5'd1;
            if (pos_reg == agd_pkg::POS_LAST)
            begin
                busy_next = 1'b0;
            end
            if (decoding)
            begin
                h2_next  = h1_reg;
                h1_next  = dec_sample;
                nib_next = nib_reg >> 4;
            end
        end

        if (load)
        begin
            busy_next  = 1'b1;
            pos_next   = agd_pkg::POS_FIRST_HIST;
            k1_next    = job.k1;
            k2_next    = job.k2;
            shift_next = job.shift;
            h1_next    = job.hist1;
            h2_next    = job.hist2;
            nib_next   = job.nibbles;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg       <= k1_next;
        k2_reg       <= k2_next;
        shift_reg    <= shift_next;
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        nib_reg      <= nib_next;
        out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

[hw/rtl/adpcm_group_decoder_4bit_top.sv]
// Decodes one 4-bit ADPCM group word (32-bit header plus 15 coded bytes) into
// 32 signed 16-bit sample words: the two header history values, then 30
// predicted samples, high nibble of each byte first. The two-tap prediction
// recursion produces one sample per cycle while sample_stall does not hold
// the output. A two-entry group queue sits between the header decode and the
// sample engine, so the next groups are taken while samples still stream out,
// and consecutive groups come out without a gap. After a group word is taken
// into an idle block, its first sample word passes through the queue entry,
// the engine state registers and the output register.
`default_nettype none

module adpcm_group_decoder_4bit_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  group_valid,
    output      logic                  group_stall,
    input  wire agd_pkg::group_word_t  group_word,
    output      logic                  sample_valid,
    input  wire logic                  sample_stall,
    output      agd_pkg::sample_word_t sample_word
);

    logic          push_valid, push_full;
    agd_pkg::job_t push_job;
    logic          pop_valid, pop;
    agd_pkg::job_t pop_job;

    agd_front u_front (
        .group_valid (group_valid),
        .group_stall (group_stall),
        .group_word  (group_word),
        .push_valid  (push_valid),
        .push_full   (push_full),
        .push_job    (push_job)
    );

    agd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_full  (push_full),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_job    (pop_job)
    );

    agd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (pop_valid),
        .job_pop      (pop),
        .job          (pop_job),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_word  (sample_word)
    );

endmodule

`default_nettype wire
